[rtl/core/bus_master_request_engine_defines.svh]
// Assertion macros shared by the bus master request engine RTL.
`ifndef BUS_MASTER_REQUEST_ENGINE_DEFINES_SVH
`define BUS_MASTER_REQUEST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BMRE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BMRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bmre_pkg.sv]
// Types and constants of the bus master request engine.
package bmre_pkg;

  // Command codes of an input word
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RX    = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Transaction status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_WRONG   = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Protocol bytes
  localparam logic [7:0] REQ_HEAD_A = 8'hD1;
  localparam logic [7:0] REQ_HEAD_B = 8'hCC;
  localparam logic [7:0] ACK_A      = 8'hA5;
  localparam logic [7:0] ACK_B      = 8'h55;

  // Response length and default timeout
  localparam int unsigned RESP_LEN      = 6;
  localparam logic [2:0]  RESP_LAST_IDX = 3'(RESP_LEN - 1);
  localparam logic [7:0]  TIMEOUT_RESET = 8'd25;
  localparam logic [7:0]  TICKS_MAX     = 8'hFF;

  // Request beats: head A, head B, address, step
  localparam logic [1:0] BEAT_HEAD_A = 2'd0;
  localparam logic [1:0] BEAT_HEAD_B = 2'd1;
  localparam logic [1:0] BEAT_ADDR   = 2'd2;
  localparam logic [1:0] BEAT_STEP   = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] slave_address;
    logic [7:0] step_value;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic [1:0]  status;
    logic [31:0] button_state;
    logic        last_of_run;
  } out_word_t;

  // Pending result run handed from the control logic to the emitter
  typedef struct packed {
    logic        is_done;
    logic [7:0]  slave_address;
    logic [7:0]  step_value;
    logic [1:0]  status;
    logic [31:0] payload;
  } run_desc_t;

endpackage

[rtl/core/bmre_emit.sv]
// Result emitter: current run plus one skid entry, expands a request into four bytes.
`include "bus_master_request_engine_defines.svh"

module bmre_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bmre_pkg::run_desc_t push_desc,
  output logic                full,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output bmre_pkg::out_word_t rsp_word
);

  logic                cur_valid, cur_valid_next;
  bmre_pkg::run_desc_t cur, cur_next;
  logic [1:0]          beat, beat_next;
  logic                skid_valid, skid_valid_next;
  bmre_pkg::run_desc_t skid, skid_next;
  logic                is_last;
  logic                pop;
  logic                cur_free;

  // Output word from the current run and beat
  always_comb begin
    rsp_word = '0;
    is_last  = cur.is_done || (beat == bmre_pkg::BEAT_STEP);
    if (cur.is_done) begin
      rsp_word.result_kind  = bmre_pkg::KIND_DONE;
      rsp_word.status       = cur.status;
      rsp_word.button_state = cur.payload;
    end else begin
      rsp_word.result_kind = bmre_pkg::KIND_TX;
      rsp_word.status      = bmre_pkg::STATUS_OK;
      case (beat)
        bmre_pkg::BEAT_HEAD_A: rsp_word.tx_byte = bmre_pkg::REQ_HEAD_A;
        bmre_pkg::BEAT_HEAD_B: rsp_word.tx_byte = bmre_pkg::REQ_HEAD_B;
        bmre_pkg::BEAT_ADDR:   rsp_word.tx_byte = cur.slave_address;
        default:               rsp_word.tx_byte = cur.step_value;
      endcase
    end
    rsp_word.last_of_run = is_last;
  end

  assign rsp_valid = cur_valid;
  assign full      = skid_valid;
  assign pop       = cur_valid && !rsp_stall && is_last;
  assign cur_free  = pop || !cur_valid;

  // Run advance and refill from skid or push
  always_comb begin
    cur_valid_next  = cur_valid;
    cur_next        = cur;
    beat_next       = beat;
    skid_valid_next = skid_valid;
    skid_next       = skid;
    if (cur_free) begin
      beat_next = bmre_pkg::BEAT_HEAD_A;
      if (skid_valid) begin
        cur_valid_next  = 1'b1;
        cur_next        = skid;
        skid_valid_next = push;
        skid_next       = push_desc;
      end else begin
        cur_valid_next = push;
        cur_next       = push_desc;
      end
    end else begin
      if (!rsp_stall) begin
        beat_next = beat + 2'd1;
      end
      if (push) begin
        skid_valid_next = 1'b1;
        skid_next       = push_desc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      skid_valid <= 1'b0;
      beat       <= bmre_pkg::BEAT_HEAD_A;
    end else begin
      cur_valid  <= cur_valid_next;
      skid_valid <= skid_valid_next;
      beat       <= beat_next;
    end
    cur  <= cur_next;
    skid <= skid_next;
  end

  // Checks
  `BMRE_ASSERT_IMP(a_skid_needs_cur, clk, rst, skid_valid, cur_valid, "skid set with no current run")
  `BMRE_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !skid_valid, "run pushed into full emitter")
  `BMRE_ASSERT_NEXT(a_beat_advance, clk, rst, cur_valid && !is_last && !rsp_stall, cur_valid && (beat == $past(beat) + 2'd1), "request beat did not advance")

endmodule

[rtl/core/bus_master_request_engine.sv]
// Top level of the bus master request engine: transaction control and emitter.
//
// Usage:
//   req channel (req_valid/req_stall/req_word) carries commands: start a
//   request, a received bus byte, or a one millisecond tick.
//   rsp channel (rsp_valid/rsp_stall/rsp_word) carries results: the four
//   request bytes D1, CC, address, step on a start, and one finished word
//   (status ok, wrong response or timeout) at the end of a transaction.
//   cfg_write_en/cfg_data write the timeout limit in ticks (reset 25).
// Latency: with the emitter idle, the first result of an input word is shown
//   the cycle after the word is taken; otherwise it follows the words already
//   queued. Transaction state updates in that same cycle.
// Throughput: one input word per cycle while req_stall is low; a start gives four
//   output words, a finish one. The emitter holds one run in flight plus one
//   waiting run, and req_stall rises while the waiting slot is taken.
// Reset: synchronous; leaves the block idle with no results pending and the
//   timeout limit at 25 ticks.
// Receiver stall: the current output word holds; input words are still taken
//   until the waiting slot fills.
`include "bus_master_request_engine_defines.svh"

module bus_master_request_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [7:0]          cfg_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  bmre_pkg::in_word_t  req_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output bmre_pkg::out_word_t rsp_word
);

  logic [7:0]          timeout_limit;
  logic                waiting, waiting_next;
  logic [2:0]          received_count, received_count_next;
  logic [7:0]          elapsed_ticks, elapsed_ticks_next;
  logic [7:0]          response_store [bmre_pkg::RESP_LEN];
  logic [7:0]          ticks_inc;
  logic                accept;
  logic                store_write;
  logic                push;
  bmre_pkg::run_desc_t push_desc;

  assign accept = req_valid && !req_stall;

  // Timeout limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= bmre_pkg::TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_limit <= cfg_data;
    end
  end

  // Transaction control
  always_comb begin
    waiting_next        = waiting;
    received_count_next = received_count;
    elapsed_ticks_next  = elapsed_ticks;
    push                = 1'b0;
    push_desc           = '0;
    store_write         = 1'b0;
    ticks_inc = (elapsed_ticks == bmre_pkg::TICKS_MAX) ? elapsed_ticks
                                                        : elapsed_ticks + 8'd1;
    if (accept) begin
      case (req_word.command)
        bmre_pkg::CMD_START: begin
          if (!waiting) begin
            waiting_next            = 1'b1;
            received_count_next     = '0;
            elapsed_ticks_next      = '0;
            push                    = 1'b1;
            push_desc.is_done       = 1'b0;
            push_desc.slave_address = req_word.slave_address;
            push_desc.step_value    = req_word.step_value;
          end
        end
        bmre_pkg::CMD_RX: begin
          if (waiting) begin
            store_write         = (received_count <= bmre_pkg::RESP_LAST_IDX);
            received_count_next = received_count + 3'd1;
            if (received_count == bmre_pkg::RESP_LAST_IDX) begin
              waiting_next      = 1'b0;
              push              = 1'b1;
              push_desc.is_done = 1'b1;
              // sixth byte is on the input now, not yet in the store
              if (response_store[0] == bmre_pkg::ACK_A &&
                  response_store[1] == bmre_pkg::ACK_B) begin
                push_desc.status  = bmre_pkg::STATUS_OK;
                push_desc.payload = {req_word.rx_byte, response_store[4],
                                     response_store[3], response_store[2]};
              end else begin
                push_desc.status = bmre_pkg::STATUS_WRONG;
              end
            end
          end
        end
        bmre_pkg::CMD_TICK: begin
          if (waiting) begin
            elapsed_ticks_next = ticks_inc;
            if (ticks_inc >= timeout_limit) begin
              waiting_next      = 1'b0;
              push              = 1'b1;
              push_desc.is_done = 1'b1;
              push_desc.status  = bmre_pkg::STATUS_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting        <= 1'b0;
      received_count <= '0;
      elapsed_ticks  <= '0;
    end else begin
      waiting        <= waiting_next;
      received_count <= received_count_next;
      elapsed_ticks  <= elapsed_ticks_next;
    end
  end

  // Response byte store
  always_ff @(posedge clk) begin
    if (store_write) begin
      response_store[received_count] <= req_word.rx_byte;
    end
  end

  bmre_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  // Checks
  `BMRE_ASSERT_IMP(a_count_in_range, clk, rst, waiting, received_count <= bmre_pkg::RESP_LAST_IDX, "response count past end while waiting")
  `BMRE_ASSERT_NEXT(a_start_clears, clk, rst, accept && !waiting && (req_word.command == bmre_pkg::CMD_START), waiting && (received_count == 3'd0) && (elapsed_ticks == 8'd0), "start did not open a clean transaction")
  `BMRE_ASSERT_NEXT(a_done_ends, clk, rst, push && push_desc.is_done, !waiting, "finished run left transaction open")

endmodule
